/* sv/mse_pkg.sv */
// ----------------------------------------------------------------------------
// mse_pkg
// shared opcodes, function codes, alu operations and the decoded control
// bundle for the execute unit
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned RegWidth  = 5;

    typedef logic [DataWidth-1:0] data_t;
    typedef logic [RegWidth-1:0]  reg_idx_t;
    typedef logic [5:0]           code_t;

    // major opcodes
    localparam code_t OP_RTYPE = 6'h00;
    localparam code_t OP_ADDI  = 6'h08;
    localparam code_t OP_ADDIU = 6'h09;
    localparam code_t OP_ANDI  = 6'h0C;
    localparam code_t OP_ORI   = 6'h0D;
    localparam code_t OP_XORI  = 6'h0E;
    localparam code_t OP_LUI   = 6'h0F;
    localparam code_t OP_LW    = 6'h23;
    localparam code_t OP_SW    = 6'h2B;

    // r-type function codes
    localparam code_t FN_SLL  = 6'h00;
    localparam code_t FN_SRL  = 6'h02;
    localparam code_t FN_SRA  = 6'h03;
    localparam code_t FN_ADD  = 6'h20;
    localparam code_t FN_ADDU = 6'h21;
    localparam code_t FN_SUB  = 6'h22;
    localparam code_t FN_SUBU = 6'h23;
    localparam code_t FN_AND  = 6'h24;
    localparam code_t FN_OR   = 6'h25;
    localparam code_t FN_XOR  = 6'h26;
    localparam code_t FN_NOR  = 6'h27;
    localparam code_t FN_SLT  = 6'h2A;
    localparam code_t FN_SLTU = 6'h2B;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_NOR,
        ALU_SLT,
        ALU_SLTU,
        ALU_SLL,
        ALU_SRL,
        ALU_SRA,
        ALU_LUI
    } alu_op_t;

    typedef struct packed {
        alu_op_t   alu_op;
        logic      use_imm;
        data_t     imm_ext;
        logic [4:0] shamt;
        reg_idx_t  dst_idx;
        logic      write_reg;
        logic      is_load;
    } decode_t;

endpackage

/* sv/mse_issue_if.sv */
// ----------------------------------------------------------------------------
// mse_issue_if
// instruction channel: instruction word and its two source values
// ----------------------------------------------------------------------------
interface mse_issue_if;
    logic               valid;
    logic               ready;
    logic        [31:0] instruction;
    logic signed [31:0] rs_value;
    logic signed [31:0] rt_value;

    modport source (output valid, output instruction, output rs_value,
                    output rt_value, input ready);
    modport sink   (input valid, input instruction, input rs_value,
                    input rt_value, output ready);
endinterface

/* sv/mse_complete_if.sv */
// ----------------------------------------------------------------------------
// mse_complete_if
// result channel: alu result, destination register and flags
// ----------------------------------------------------------------------------
interface mse_complete_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic        [4:0]  dst_idx;
    logic               write_reg;
    logic               is_load;

    modport source (output valid, output result, output dst_idx,
                    output write_reg, output is_load, input ready);
    modport sink   (input valid, input result, input dst_idx,
                    input write_reg, input is_load, output ready);
endinterface

/* sv/mips_subset_execute_unit.sv */
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// execute stage for a mips32 integer subset: input register, decode and alu,
// result register
// ----------------------------------------------------------------------------
// an accepted instruction is held in the input register, decoded and executed, then
// held in the result register, from which it is offered on the complete channel
// throughput: one transaction per cycle while complete.ready is not held low, set by
// the single alu pass between the input register and the result register
// reset: rst_n clears both stage valid flags; payload registers are not reset
// ----------------------------------------------------------------------------
module mips_subset_execute_unit
    import mse_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    mse_issue_if.sink      issue,
    mse_complete_if.source complete
);

    logic     in_valid_reg;
    logic     in_valid_next;
    data_t    instr_reg;
    data_t    rs_reg;
    data_t    rt_reg;

    logic     out_valid_reg;
    logic     out_valid_next;
    data_t    result_reg;
    reg_idx_t dst_idx_reg;
    logic     write_reg_reg;
    logic     is_load_reg;

    logic     out_free;
    logic     advance;
    logic     take;
    decode_t  dec;
    data_t    alu_result;

    assign out_free    = !out_valid_reg || complete.ready;
    assign advance     = in_valid_reg && out_free;
    assign issue.ready = !in_valid_reg || out_free;
    assign take        = issue.valid && issue.ready;

    assign in_valid_next  = take || (in_valid_reg && !out_free);
    assign out_valid_next = advance || (out_valid_reg && !complete.ready);

    mse_decode u_decode
    (
        .instruction (instr_reg),
        .dec         (dec)
    );

    mse_alu u_alu
    (
        .dec      (dec),
        .rs_value (rs_reg),
        .rt_value (rt_reg),
        .result   (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            instr_reg <= issue.instruction;
            rs_reg    <= data_t'(issue.rs_value);
            rt_reg    <= data_t'(issue.rt_value);
        end
        if (advance)
        begin
            result_reg    <= alu_result;
            dst_idx_reg   <= dec.dst_idx;
            write_reg_reg <= dec.write_reg;
            is_load_reg   <= dec.is_load;
        end
    end

    assign complete.valid     = out_valid_reg;
    assign complete.result    = $signed(result_reg);
    assign complete.dst_idx   = dst_idx_reg;
    assign complete.write_reg = write_reg_reg;
    assign complete.is_load   = is_load_reg;

endmodule

/* sv/mse_decode.sv */
// ----------------------------------------------------------------------------
// mse_decode
// instruction decoder: alu operation, operand select, immediate extension
// and destination register
// ----------------------------------------------------------------------------
module mse_decode
    import mse_pkg::*;
(
    input  logic [31:0] instruction,
    output decode_t     dec
);

    code_t    opcode;
    code_t    funct;
    reg_idx_t rt;
    reg_idx_t rd;
    logic [15:0] imm;
    logic     zext;

    assign opcode = instruction[31:26];
    assign rt     = instruction[20:16];
    assign rd     = instruction[15:11];
    assign funct  = instruction[5:0];
    assign imm    = instruction[15:0];

    always_comb
    begin
        zext = opcode inside {OP_ADDIU, OP_ANDI, OP_ORI, OP_XORI};

        dec.alu_op   = ALU_ADD;
        dec.use_imm  = 1'b0;
        dec.imm_ext  = zext ? {16'h0000, imm} : {{16{imm[15]}}, imm};
        dec.shamt    = instruction[10:6];
        dec.dst_idx  = '0;
        dec.is_load  = (opcode == OP_LW);

        case (opcode)
            OP_RTYPE:
            begin
                dec.dst_idx = rd;
                case (funct)
                    FN_ADD, FN_ADDU: dec.alu_op = ALU_ADD;
                    FN_SUB, FN_SUBU: dec.alu_op = ALU_SUB;
                    FN_AND:          dec.alu_op = ALU_AND;
                    FN_OR:           dec.alu_op = ALU_OR;
                    FN_XOR:          dec.alu_op = ALU_XOR;
                    FN_NOR:          dec.alu_op = ALU_NOR;
                    FN_SLT:          dec.alu_op = ALU_SLT;
                    FN_SLTU:         dec.alu_op = ALU_SLTU;
                    FN_SLL:          dec.alu_op = ALU_SLL;
                    FN_SRL:          dec.alu_op = ALU_SRL;
                    FN_SRA:          dec.alu_op = ALU_SRA;
                    default:         dec.alu_op = ALU_ADD;
                endcase
            end
            OP_ADDI, OP_ADDIU, OP_LW:
            begin
                dec.use_imm = 1'b1;
                dec.dst_idx = rt;
            end
            OP_SW:
            begin
                dec.use_imm = 1'b1;
            end
            OP_ANDI:
            begin
                dec.alu_op  = ALU_AND;
                dec.use_imm = 1'b1;
                dec.dst_idx = rt;
            end
            OP_ORI:
            begin
                dec.alu_op  = ALU_OR;
                dec.use_imm = 1'b1;
                dec.dst_idx = rt;
            end
            OP_XORI:
            begin
                dec.alu_op  = ALU_XOR;
                dec.use_imm = 1'b1;
                dec.dst_idx = rt;
            end
            OP_LUI:
            begin
                dec.alu_op  = ALU_LUI;
                dec.use_imm = 1'b1;
                dec.dst_idx = rt;
            end
            default:
            begin
                dec.alu_op = ALU_ADD;
            end
        endcase

        dec.write_reg = (dec.dst_idx != '0);
    end

endmodule

/* sv/mse_alu.sv */
// ----------------------------------------------------------------------------
// mse_alu
// 32-bit integer alu: add, subtract, logic, load upper immediate, compares and shifts
// ----------------------------------------------------------------------------
module mse_alu
    import mse_pkg::*;
(
    input  decode_t dec,
    input  data_t   rs_value,
    input  data_t   rt_value,
    output data_t   result
);

    data_t a;
    data_t b;

    assign a = rs_value;
    assign b = dec.use_imm ? dec.imm_ext : rt_value;

    always_comb
    begin
        case (dec.alu_op)
            ALU_ADD:  result = a + b;
            ALU_SUB:  result = a - b;
            ALU_AND:  result = a & b;
            ALU_OR:   result = a | b;
            ALU_XOR:  result = a ^ b;
            ALU_NOR:  result = ~(a | b);
            ALU_SLT:  result = {31'd0, ($signed(a) < $signed(b))};
            ALU_SLTU: result = {31'd0, (a < b)};
            ALU_SLL:  result = b << dec.shamt;
            ALU_SRL:  result = b >> dec.shamt;
            ALU_SRA:  result = data_t'($signed(b) >>> dec.shamt);
            ALU_LUI:  result = {dec.imm_ext[15:0], 16'h0000};
            default:  result = a + b;
        endcase
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for mips_subset_execute_unit: a queue-fed driver offers
// instruction transactions, every accepted one is predicted into a queue of
// expected results, and a monitor compares each completed transaction field
// by field while both sides idle and stall at random in several phases
// ----------------------------------------------------------------------------
module testbench;
    import mse_pkg::*;

    localparam int     QUIET_LIMIT  = 2000;
    localparam int     RANDOM_ITEMS = 1622;
    localparam int     HOLD_AT      = 200;
    localparam int     HOLD_CYCLES  = 60;
    localparam int     DRAIN_CYCLES = 8;
    localparam code_t  OP_BEQ       = 6'h04;
    localparam code_t  FN_UNLISTED  = 6'h3F;
    localparam code_t  FN_UNUSED    = 6'h01;

    typedef struct {
        logic        [31:0] instruction;
        logic signed [31:0] rs_value;
        logic signed [31:0] rt_value;
    } instr_txn_t;

    typedef struct {
        data_t    result;
        reg_idx_t dst_idx;
        logic     write_reg;
        logic     is_load;
    } exec_result_t;

    logic clk = 1'b0;
    logic rst_n;

    mse_issue_if    issue_ch ();
    mse_complete_if complete_ch ();

    mips_subset_execute_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (issue_ch),
        .complete (complete_ch)
    );

    instr_txn_t   pending_instrs[$];
    exec_result_t expected_results[$];

    int accepted_count;
    int results_checked;
    int error_count;
    int total_items;
    int quiet_cycles;
    int hold_left;
    logic hold_started;
    int tx_idle_pct;
    int rx_stall_pct;
    int n_rtype;
    int n_imm;
    int n_mem;
    int n_other;

    code_t fn_list [13] = '{FN_SLL, FN_SRL, FN_SRA, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
                            FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    code_t op_list [8]  = '{OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
                            OP_LW, OP_SW};

    always #5 clk = ~clk;

    function automatic exec_result_t predict_execute(input instr_txn_t t);
        code_t        opc;
        code_t        fn;
        reg_idx_t     rt_f;
        reg_idx_t     rd_f;
        logic [4:0]   sh;
        logic [15:0]  imm;
        data_t        a;
        data_t        b;
        data_t        ext;
        data_t        res;
        reg_idx_t     dest;
        exec_result_t r;
        opc  = t.instruction[31:26];
        rt_f = t.instruction[20:16];
        rd_f = t.instruction[15:11];
        sh   = t.instruction[10:6];
        fn   = t.instruction[5:0];
        imm  = t.instruction[15:0];
        a    = t.rs_value;
        b    = t.rt_value;
        dest = '0;
        case (opc)
            OP_ADDIU, OP_ANDI, OP_ORI, OP_XORI: ext = {16'h0000, imm};
            default:                            ext = {{16{imm[15]}}, imm};
        endcase
        case (opc)
            OP_RTYPE:
            begin
                dest = rd_f;
                case (fn)
                    FN_ADD, FN_ADDU: res = a + b;
                    FN_SUB, FN_SUBU: res = a - b;
                    FN_AND:          res = a & b;
                    FN_OR:           res = a | b;
                    FN_XOR:          res = a ^ b;
                    FN_NOR:          res = ~(a | b);
                    FN_SLT:          res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                    FN_SLTU:         res = (a < b) ? 32'd1 : 32'd0;
                    FN_SLL:          res = b << sh;
                    FN_SRL:          res = b >> sh;
                    FN_SRA:          res = data_t'($signed(b) >>> sh);
                    default:         res = a + b;
                endcase
            end
            OP_ADDI, OP_ADDIU, OP_LW:
            begin
                res  = a + ext;
                dest = rt_f;
            end
            OP_SW:   res = a + ext;
            OP_ANDI:
            begin
                res  = a & ext;
                dest = rt_f;
            end
            OP_ORI:
            begin
                res  = a | ext;
                dest = rt_f;
            end
            OP_XORI:
            begin
                res  = a ^ ext;
                dest = rt_f;
            end
            OP_LUI:
            begin
                res  = {imm, 16'h0000};
                dest = rt_f;
            end
            default: res = a + b;
        endcase
        r.result    = res;
        r.dst_idx   = dest;
        r.write_reg = (dest != '0);
        r.is_load   = (opc == OP_LW);
        return r;
    endfunction

    function automatic logic [31:0] encode_r(input code_t fn, input reg_idx_t rd,
                                             input logic [4:0] sh);
        return {OP_RTYPE, 5'd3, 5'd4, rd, sh, fn};
    endfunction

    function automatic logic [31:0] encode_i(input code_t op, input reg_idx_t rt,
                                             input logic [15:0] imm);
        return {op, 5'd7, rt, imm};
    endfunction

    function automatic data_t pick_operand();
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(4))
                0:       return 32'h0000_0000;
                1:       return 32'h0000_0001;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_instruction();
        int          kind;
        logic [31:0] w;
        kind = $urandom_range(99);
        w    = $urandom;
        if (kind < 45)
        begin
            w[31:26] = OP_RTYPE;
            w[5:0]   = fn_list[$urandom_range(12)];
        end
        else if (kind < 80)
        begin
            w[31:26] = op_list[$urandom_range(7)];
        end
        else if (kind < 90)
        begin
            w[31:26] = OP_RTYPE;
        end
        return w;
    endfunction

    task automatic add_item(input logic [31:0] word, input data_t a, input data_t b);
        instr_txn_t t;
        t.instruction = word;
        t.rs_value    = a;
        t.rt_value    = b;
        pending_instrs.insert(pending_instrs.size(), t);
    endtask

    // idling phases: none, sender, receiver, both lightly
    always_comb
    begin
        if (accepted_count < 450)
        begin
            tx_idle_pct  = 0;
            rx_stall_pct = 0;
        end
        else if (accepted_count < 850)
        begin
            tx_idle_pct  = 55;
            rx_stall_pct = 0;
        end
        else if (accepted_count < 1250)
        begin
            tx_idle_pct  = 0;
            rx_stall_pct = 55;
        end
        else
        begin
            tx_idle_pct  = 7;
            rx_stall_pct = 7;
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        instr_txn_t got;
        instr_txn_t next_txn;
        if (!rst_n)
        begin
            issue_ch.valid       <= 1'b0;
            issue_ch.instruction <= '0;
            issue_ch.rs_value    <= '0;
            issue_ch.rt_value    <= '0;
            accepted_count       <= 0;
        end
        else
        begin
            if (issue_ch.valid && issue_ch.ready)
            begin
                got.instruction = issue_ch.instruction;
                got.rs_value    = issue_ch.rs_value;
                got.rt_value    = issue_ch.rt_value;
                expected_results.insert(expected_results.size(), predict_execute(got));
                case (got.instruction[31:26])
                    OP_RTYPE:                                      n_rtype++;
                    OP_LW, OP_SW:                                  n_mem++;
                    OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_XORI,
                    OP_LUI:                                        n_imm++;
                    default:                                       n_other++;
                endcase
                accepted_count <= accepted_count + 1;
            end
            if (!issue_ch.valid || issue_ch.ready)
            begin
                if (pending_instrs.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    next_txn = pending_instrs.pop_front();
                    issue_ch.instruction <= next_txn.instruction;
                    issue_ch.rs_value    <= next_txn.rs_value;
                    issue_ch.rt_value    <= next_txn.rt_value;
                    issue_ch.valid       <= 1'b1;
                end
                else
                begin
                    issue_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            hold_started <= 1'b0;
        end
        else if (!hold_started && accepted_count >= HOLD_AT)
        begin
            hold_left    <= HOLD_CYCLES;
            hold_started <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        exec_result_t want;
        if (!rst_n)
        begin
            complete_ch.ready <= 1'b0;
        end
        else
        begin
            if (complete_ch.valid && complete_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected: result %h dst_idx %0d",
                           complete_ch.result, complete_ch.dst_idx);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (complete_ch.result !== want.result)
                    begin
                        $error("result: expected %h, actual %h", want.result,
                               complete_ch.result);
                        error_count++;
                    end
                    if (complete_ch.dst_idx !== want.dst_idx)
                    begin
                        $error("dst_idx: expected %0d, actual %0d", want.dst_idx,
                               complete_ch.dst_idx);
                        error_count++;
                    end
                    if (complete_ch.write_reg !== want.write_reg)
                    begin
                        $error("write_reg: expected %b, actual %b", want.write_reg,
                               complete_ch.write_reg);
                        error_count++;
                    end
                    if (complete_ch.is_load !== want.is_load)
                    begin
                        $error("is_load: expected %b, actual %b", want.is_load,
                               complete_ch.is_load);
                        error_count++;
                    end
                end
            end
            complete_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((issue_ch.valid && issue_ch.ready) ||
                 (complete_ch.valid && complete_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("no transaction for %0d cycles, %0d results still expected",
                 QUIET_LIMIT, expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;

        // overflow wraps, bitwise patterns, compares at the sign boundary
        add_item(encode_r(FN_ADD, 5'd31, 5'd0), 32'h7FFF_FFFF, 32'h0000_0001);
        add_item(encode_r(FN_ADDU, 5'd1, 5'd0), 32'hFFFF_FFFF, 32'h0000_0001);
        add_item(encode_r(FN_SUB, 5'd2, 5'd0), 32'h8000_0000, 32'h0000_0001);
        add_item(encode_r(FN_SUBU, 5'd3, 5'd0), 32'h0000_0000, 32'h0000_0001);
        add_item(encode_r(FN_AND, 5'd4, 5'd0), 32'hAAAA_AAAA, 32'hFFFF_FFFF);
        add_item(encode_r(FN_OR, 5'd5, 5'd0), 32'h5555_5555, 32'hAAAA_AAAA);
        add_item(encode_r(FN_XOR, 5'd6, 5'd0), 32'hFFFF_FFFF, 32'h5555_5555);
        add_item(encode_r(FN_NOR, 5'd7, 5'd0), 32'h0000_0000, 32'h0000_0000);
        add_item(encode_r(FN_SLT, 5'd8, 5'd0), 32'hFFFF_FFFF, 32'h0000_0001);
        add_item(encode_r(FN_SLT, 5'd9, 5'd0), 32'h7FFF_FFFF, 32'h8000_0000);
        add_item(encode_r(FN_SLTU, 5'd10, 5'd0), 32'hFFFF_FFFF, 32'h0000_0001);
        add_item(encode_r(FN_SLTU, 5'd11, 5'd0), 32'h0000_0000, 32'hFFFF_FFFF);
        // shifts at both shift-amount extremes, rs ignored
        add_item(encode_r(FN_SLL, 5'd12, 5'd31), 32'hDEAD_BEEF, 32'h0000_0001);
        add_item(encode_r(FN_SRL, 5'd13, 5'd31), 32'hDEAD_BEEF, 32'h8000_0000);
        add_item(encode_r(FN_SRA, 5'd14, 5'd31), 32'hDEAD_BEEF, 32'h8000_0000);
        add_item(encode_r(FN_SRA, 5'd15, 5'd0), 32'hDEAD_BEEF, 32'h8000_0001);
        // immediates: sign versus zero extension, lui ignores both sources
        add_item(encode_i(OP_ADDI, 5'd16, 16'h8000), 32'h8000_0000, 32'h1234_5678);
        add_item(encode_i(OP_ADDIU, 5'd17, 16'hFFFF), 32'hFFFF_FFFF, 32'h0000_0000);
        add_item(encode_i(OP_ANDI, 5'd18, 16'hFFFF), 32'hFFFF_FFFF, 32'h0000_0000);
        add_item(encode_i(OP_ORI, 5'd19, 16'h8000), 32'h0000_0000, 32'hFFFF_FFFF);
        add_item(encode_i(OP_XORI, 5'd20, 16'hFFFF), 32'h1234_5678, 32'h0000_0000);
        add_item(encode_i(OP_LUI, 5'd31, 16'hFFFF), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // load into register zero, store never writes
        add_item(encode_i(OP_LW, 5'd0, 16'hFFFC), 32'h0000_1000, 32'h0000_0000);
        add_item(encode_i(OP_SW, 5'd21, 16'h7FFF), 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        // unlisted function codes and opcodes fall back to add
        add_item(encode_r(FN_UNLISTED, 5'd0, 5'd0), 32'h0000_0005, 32'h0000_0007);
        add_item(encode_r(FN_UNUSED, 5'd22, 5'd9), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(encode_i(OP_BEQ, 5'd23, 16'h0010), 32'h8000_0000, 32'h8000_0000);
        add_item(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_item(pick_instruction(), pick_operand(), pick_operand());
        total_items = pending_instrs.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_items || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count += expected_results.size();
        end

        $display("checked %0d of %0d instructions: %0d r-type, %0d immediate, %0d load/store,",
                 results_checked, accepted_count, n_rtype, n_imm, n_mem);
        $display("%0d unlisted opcodes; idle and stall phases plus one %0d-cycle output hold",
                 n_other, HOLD_CYCLES);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
